### hw/rtl/cdeq_pkg.sv
// Shared types and constants of the circular double-ended queue.
package cdeq_pkg;

   // Width of one stored word
   localparam int WORD_W = 32;
   // Width of the capacity register
   localparam int CAP_W = 9;
   // Capacity after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

   // Operation codes of a request transaction
   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_REAR  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_REAR   = 3'd3,
      OP_PEEK       = 3'd4
   } op_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_RESP
   } state_type;

   // Request transaction payload
   typedef struct packed {
      logic [2:0]               operation;
      logic signed [WORD_W-1:0] value;
   } req_payload_type;

   // Response transaction payload
   typedef struct packed {
      logic                     accepted;
      logic signed [WORD_W-1:0] front_word;
      logic signed [WORD_W-1:0] rear_word;
      logic                     is_empty;
      logic                     is_full;
   } rsp_payload_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic execute;
      logic fetch;
   } cmd_type;

endpackage

### hw/rtl/circular_double_ended_queue.sv
// Top level of the circular double-ended queue.
//
// Bounded double-ended queue of signed 32-bit words held in a ring store.
// Request channel (req_valid, req_stall, req_payload): a transaction carries
// an operation (push front, push rear, pop front, pop rear, peek) and a word.
// Response channel (rsp_valid, rsp_stall, rsp_payload): one transaction per
// request with the accepted flag, the front and rear words (all ones when
// empty) and the empty and full flags after the operation.
// Configuration: csr_wr_en with csr_wr_data writes the capacity; write it
// only while no request is in flight. Capacity is saturated at MAX_DEPTH.
// The response is valid once the controller has passed through its execute
// and read states after the request is taken. The controller takes load,
// execute (store write), store read and respond in turn, one request at a
// time. Reset: pointers return to an empty ring (front 1, rear 0),
// occupancy and controller clear, capacity returns to 256; the ring store
// is not cleared and needs no sweep.
// A stalled response holds its payload; req_stall stays high until the
// response transaction completes.
module circular_double_ended_queue #(
   parameter int MAX_DEPTH = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  cdeq_pkg::req_payload_type         req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output cdeq_pkg::rsp_payload_type         rsp_payload,
   input  logic                              csr_wr_en,
   input  logic [cdeq_pkg::CAP_W-1:0]        csr_wr_data
);

   cdeq_pkg::cmd_type cmd;

   // Sequence each transaction
   cdeq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Hold the ring and compute the response
   cdeq_datapath #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_payload (rsp_payload)
   );

endmodule

### hw/rtl/cdeq_ctrl.sv
// Controller state machine: handshakes and sequencing of one transaction.
module cdeq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output cdeq_pkg::cmd_type  cmd
);

   cdeq_pkg::state_type state_ff;
   cdeq_pkg::state_type state_in;

   // Hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cdeq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Advance through load, execute, read and respond
   always_comb begin
      state_in    = state_ff;
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      cmd.load    = 1'b0;
      cmd.execute = 1'b0;
      cmd.fetch   = 1'b0;
      unique case (state_ff)
         cdeq_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = cdeq_pkg::ST_EXEC;
            end
         end
         cdeq_pkg::ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = cdeq_pkg::ST_READ;
         end
         cdeq_pkg::ST_READ: begin
            cmd.fetch = 1'b1;
            state_in  = cdeq_pkg::ST_RESP;
         end
         cdeq_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = cdeq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cdeq_pkg::ST_IDLE;
         end
      endcase
   end

   // A new request is never taken while a response waits
   assert property (@(posedge clock) disable iff (reset) !req_stall |-> !rsp_valid)
      else $error("request taken while a response is pending");

   // An accepted request is executed in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> cmd.execute)
      else $error("accepted request not executed");

   // A store read is followed by a response
   assert property (@(posedge clock) disable iff (reset) cmd.fetch |=> rsp_valid)
      else $error("store read not followed by a response");

endmodule

### hw/rtl/cdeq_datapath.sv
// Datapath: ring store, pointers, occupancy, capacity and response registers.
module cdeq_datapath #(
   parameter int MAX_DEPTH = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cdeq_pkg::cmd_type                   cmd,
   input  cdeq_pkg::req_payload_type           req_payload,
   input  logic                                csr_wr_en,
   input  logic [cdeq_pkg::CAP_W-1:0]          csr_wr_data,
   output cdeq_pkg::rsp_payload_type           rsp_payload
);

   localparam int PTR_W = $clog2(MAX_DEPTH);
   localparam int OCC_W = $clog2(MAX_DEPTH + 1);
   localparam int CMP_W = (OCC_W > cdeq_pkg::CAP_W) ? OCC_W : cdeq_pkg::CAP_W;
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(MAX_DEPTH - 1);
   localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(MAX_DEPTH);

   logic [cdeq_pkg::WORD_W-1:0] mem [MAX_DEPTH];

   logic [2:0]                   op_ff;
   logic [cdeq_pkg::WORD_W-1:0]  value_ff;
   logic [PTR_W-1:0]             front_ff, front_in;
   logic [PTR_W-1:0]             rear_ff, rear_in;
   logic [OCC_W-1:0]             occ_ff, occ_in;
   logic [cdeq_pkg::CAP_W-1:0]   cap_ff;
   logic                         ok_ff, ok_in;
   logic [cdeq_pkg::WORD_W-1:0]  front_word_ff;
   logic [cdeq_pkg::WORD_W-1:0]  rear_word_ff;
   logic                         wr_en;
   logic [PTR_W-1:0]             wr_addr;
   logic [CMP_W-1:0]             occ_cmp;
   logic [CMP_W-1:0]             cap_cmp;
   logic [CMP_W-1:0]             cap_eff;
   logic                         full;
   logic                         empty;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_LAST : p - PTR_W'(1);
   endfunction

   // Compare occupancy against the capacity, saturated at the store depth
   always_comb begin
      occ_cmp = CMP_W'(occ_ff);
      cap_cmp = CMP_W'(cap_ff);
      cap_eff = (cap_cmp > DEPTH_CMP) ? DEPTH_CMP : cap_cmp;
      full    = occ_cmp >= cap_eff;
      empty   = occ_ff == '0;
   end

   // Decode the operation into pointer moves and a store write
   always_comb begin
      front_in = front_ff;
      rear_in  = rear_ff;
      occ_in   = occ_ff;
      ok_in    = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = ptr_dec(front_ff);
      unique case (op_ff)
         cdeq_pkg::OP_PUSH_FRONT: begin
            if (!full) begin
               front_in = ptr_dec(front_ff);
               wr_addr  = ptr_dec(front_ff);
               wr_en    = 1'b1;
               occ_in   = occ_ff + OCC_W'(1);
               ok_in    = 1'b1;
            end
         end
         cdeq_pkg::OP_PUSH_REAR: begin
            if (!full) begin
               rear_in = ptr_inc(rear_ff);
               wr_addr = ptr_inc(rear_ff);
               wr_en   = 1'b1;
               occ_in  = occ_ff + OCC_W'(1);
               ok_in   = 1'b1;
            end
         end
         cdeq_pkg::OP_POP_FRONT: begin
            if (!empty) begin
               front_in = ptr_inc(front_ff);
               occ_in   = occ_ff - OCC_W'(1);
               ok_in    = 1'b1;
            end
         end
         cdeq_pkg::OP_POP_REAR: begin
            if (!empty) begin
               rear_in = ptr_dec(rear_ff);
               occ_in  = occ_ff - OCC_W'(1);
               ok_in   = 1'b1;
            end
         end
         cdeq_pkg::OP_PEEK: begin
            ok_in = 1'b1;
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   // Latch the request transaction
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_payload.operation;
         value_ff <= req_payload.value;
      end
   end

   // Hold pointers, occupancy and capacity
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= PTR_W'(1);
         rear_ff  <= '0;
         occ_ff   <= '0;
         cap_ff   <= cdeq_pkg::CAP_RESET;
      end else begin
         if (cmd.execute) begin
            front_ff <= front_in;
            rear_ff  <= rear_in;
            occ_ff   <= occ_in;
         end
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   // Keep the outcome flag
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         ok_ff <= ok_in;
      end
   end

   // Write the pushed word and read both ends of the ring
   always_ff @(posedge clock) begin
      if (cmd.execute && wr_en) begin
         mem[wr_addr] <= value_ff;
      end
      if (cmd.fetch) begin
         front_word_ff <= mem[front_ff];
         rear_word_ff  <= mem[rear_ff];
      end
   end

   // Drive the response, all ones at both ends when empty
   always_comb begin
      rsp_payload.accepted   = ok_ff;
      rsp_payload.front_word = empty ? '1 : front_word_ff;
      rsp_payload.rear_word  = empty ? '1 : rear_word_ff;
      rsp_payload.is_empty   = empty;
      rsp_payload.is_full    = full;
   end

   // Occupancy never exceeds the store depth
   assert property (@(posedge clock) disable iff (reset)
      CMP_W'(occ_ff) <= DEPTH_CMP)
      else $error("occupancy above store depth");

   // An accepted push raises the occupancy by one
   assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && wr_en) |=> (occ_ff == $past(occ_ff) + OCC_W'(1)))
      else $error("push did not raise occupancy");

   // An empty ring has the rear pointer just behind the front pointer
   assert property (@(posedge clock) disable iff (reset)
      (occ_ff == '0) |-> (rear_ff == ptr_dec(front_ff)))
      else $error("pointers inconsistent on empty ring");

endmodule
